// ----- hw/rtl/fswt_pkg.sv -----
package fswt_pkg;

    localparam int FLOW_SLOTS_DEF = 32;

    localparam int KEY_W   = 64;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int MEAN_W  = 24;
    localparam int GAP_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 168;

    // shared multiplier: 32 x 16, divider works on a 49-bit dividend
    localparam int MUL_A_W = 32;
    localparam int PROD_W  = MUL_A_W + CNT_W;
    localparam int DVD_W   = PROD_W + 1;
    localparam int STEP_W  = $clog2(DVD_W);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GAP   = 2'd1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 32'd2560;
    localparam logic [CFG_W-1:0] INITIAL_GAP_RST   = 32'd2560;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic [GAP_W-1:0]  mean_gap;
        logic [LEN_W-1:0]  max_length;
        logic [LEN_W-1:0]  min_length;
        logic [MEAN_W-1:0] mean_length;
        logic [CNT_W-1:0]  count;
        logic [KEY_W-1:0]  key;
    } entry_t;

endpackage

// ----- hw/rtl/flow_stats_window_table.sv -----
// Channel   | Ports                          | Contents
// ----------+--------------------------------+------------------------------------------
// input     | s_tvalid s_tready s_tdata s_tuser | packet record or end-of-input flush
// result    | m_tvalid m_tready m_tdata m_tlast | one flow report per beat
// config    | cfg_wr_en cfg_index cfg_wdata  | window_length, initial_gap
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Flush: every slot is scanned in turn; a live slot also passes through a report state
// (registered table read), which waits out any output stall. Key search: a live slot
// also passes through a compare state. Merge after the key hit runs the bit-serial divider
// (49 steps per division, two divisions); one division while the count is two or less.
// Synchronous active-low reset clears valid bits, window start and control, and loads config defaults.
module flow_stats_window_table #(
    parameter int FLOW_SLOTS = fswt_pkg::FLOW_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] flow_key, [79:64] packet_length, [111:80] timestamp
    input  logic [fswt_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] report_key, [79:64] report_count, [103:80] report_mean_length,
    // [119:104] report_min_length, [135:120] report_max_length,
    // [167:136] report_mean_gap
    output logic [fswt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [fswt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fswt_pkg::CFG_W-1:0]        cfg_wdata
);
    import fswt_pkg::*;

    localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int SCAN_W = $clog2(FLOW_SLOTS + 1);
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(FLOW_SLOTS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FL_SCAN = 4'd1;
    localparam logic [3:0] ST_FL_OUT  = 4'd2;
    localparam logic [3:0] ST_SR_SCAN = 4'd3;
    localparam logic [3:0] ST_SR_CMP  = 4'd4;
    localparam logic [3:0] ST_MUL1    = 4'd5;
    localparam logic [3:0] ST_LD1     = 4'd6;
    localparam logic [3:0] ST_DIV1    = 4'd7;
    localparam logic [3:0] ST_MUL2    = 4'd8;
    localparam logic [3:0] ST_LD2     = 4'd9;
    localparam logic [3:0] ST_DIV2    = 4'd10;
    localparam logic [3:0] ST_WRITE   = 4'd11;

    logic [3:0]              state_reg, state_next;
    logic [CFG_W-1:0]        win_len_reg, init_gap_reg;
    logic [TIME_W-1:0]       win_start_reg, win_start_next;
    logic [FLOW_SLOTS-1:0]   valid_reg, valid_next;
    logic [SCAN_W-1:0]       scan_reg, scan_next;
    logic                    end_act_reg, end_act_next;
    logic [KEY_W-1:0]        in_key_reg;
    logic [LEN_W-1:0]        in_len_reg;
    logic [TIME_W-1:0]       in_ts_reg;
    logic                    free_found_reg, free_found_next;
    logic [SLOT_W-1:0]       free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0]       hit_slot_reg, hit_slot_next;
    entry_t                  work_reg, work_next;
    logic                    gap_div_reg, gap_div_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        divisor_reg, divisor_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;

    entry_t                  mem [FLOW_SLOTS];
    entry_t                  rd_data_reg;
    logic                    rd_en;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    entry_t                  mem_wdata;

    logic [SLOT_W-1:0]       slot;
    logic                    more_live;
    logic                    out_free;
    logic [TIME_W:0]         win_end;
    logic [MUL_A_W-1:0]      mul_a;
    logic [CNT_W-1:0]        mul_b;
    logic [CNT_W:0]          rem_sh;
    logic                    qbit;
    logic [CNT_W-1:0]        cnt_inc;
    logic [TIME_W-1:0]       gap;

    assign slot     = scan_reg[SLOT_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign win_end  = {1'b0, win_start_reg} + {1'b0, win_len_reg};
    assign rd_en    = (scan_reg < SCAN_END);
    assign cnt_inc  = (work_reg.count == COUNT_MAX) ? COUNT_MAX : work_reg.count + 1'b1;
    assign gap      = (in_ts_reg >= work_reg.last_time) ? in_ts_reg - work_reg.last_time
                                                        : '0;

    // no live slot above the current one -> this report closes the flush
    always_comb begin
        more_live = 1'b0;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (SCAN_W'(i) > scan_reg && valid_reg[i])
                more_live = 1'b1;
        end
    end

    // divider step: restoring, one quotient bit a cycle
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit   = (rem_sh >= {1'b0, divisor_reg});

    always_comb begin
        mul_a = {{(MUL_A_W-MEAN_W){1'b0}}, work_reg.mean_length};
        mul_b = cnt_inc - 1'b1;
        if (state_reg == ST_MUL2) begin
            mul_a = work_reg.mean_gap;
            mul_b = work_reg.count - CNT_W'(2);
        end
    end

    always_comb begin
        state_next      = state_reg;
        win_start_next  = win_start_reg;
        valid_next      = valid_reg;
        scan_next       = scan_reg;
        end_act_next    = end_act_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        hit_slot_next   = hit_slot_reg;
        work_next       = work_reg;
        gap_div_next    = gap_div_reg;
        prod_next       = prod_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        step_next       = step_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        mem_we          = 1'b0;
        mem_waddr       = hit_slot_reg;
        mem_wdata       = work_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    end_act_next    = s_tuser;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    if (s_tuser || {1'b0, s_tdata[111:80]} >= win_end)
                        state_next = ST_FL_SCAN;
                    else
                        state_next = ST_SR_SCAN;
                end
            end
            ST_FL_SCAN: begin
                if (scan_reg == SCAN_END) begin
                    scan_next = '0;
                    if (end_act_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        win_start_next = win_start_reg + win_len_reg;
                        state_next     = ST_SR_SCAN;
                    end
                end else if (valid_reg[slot]) begin
                    state_next = ST_FL_OUT;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_FL_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rd_data_reg.mean_gap, rd_data_reg.max_length,
                                     rd_data_reg.min_length, rd_data_reg.mean_length,
                                     rd_data_reg.count, rd_data_reg.key};
                    m_tlast_next  = !more_live;
                    valid_next[slot] = 1'b0;
                    scan_next     = scan_reg + 1'b1;
                    state_next    = ST_FL_SCAN;
                end
            end
            ST_SR_SCAN: begin
                if (scan_reg == SCAN_END) begin
                    state_next = ST_IDLE;
                    if (free_found_reg) begin
                        mem_we                = 1'b1;
                        mem_waddr             = free_slot_reg;
                        mem_wdata.key         = in_key_reg;
                        mem_wdata.count       = CNT_W'(1);
                        mem_wdata.mean_length = {in_len_reg, 8'd0};
                        mem_wdata.min_length  = in_len_reg;
                        mem_wdata.max_length  = in_len_reg;
                        mem_wdata.mean_gap    = init_gap_reg;
                        mem_wdata.last_time   = in_ts_reg;
                        valid_next[free_slot_reg] = 1'b1;
                    end
                end else if (valid_reg[slot]) begin
                    state_next = ST_SR_CMP;
                end else begin
                    if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = slot;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_SR_CMP: begin
                if (rd_data_reg.key == in_key_reg) begin
                    work_next     = rd_data_reg;
                    hit_slot_next = slot;
                    state_next    = ST_MUL1;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SR_SCAN;
                end
            end
            ST_MUL1: begin
                prod_next       = mul_a * mul_b;
                work_next.count = cnt_inc;
                state_next      = ST_LD1;
            end
            ST_LD1: begin
                dvd_next     = {1'b0, prod_reg} + DVD_W'({in_len_reg, 8'd0});
                divisor_next = work_reg.count;
                rem_next     = '0;
                step_next    = '0;
                state_next   = ST_DIV1;
            end
            ST_DIV1, ST_DIV2: begin
                rem_next  = qbit ? CNT_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[CNT_W-1:0];
                dvd_next  = {dvd_reg[DVD_W-2:0], qbit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = (state_reg == ST_DIV1) ? ST_MUL2 : ST_WRITE;
            end
            ST_MUL2: begin
                work_next.mean_length = dvd_reg[MEAN_W-1:0];
                if (work_reg.count <= CNT_W'(2)) begin
                    work_next.mean_gap = gap;
                    gap_div_next       = 1'b0;
                    state_next         = ST_WRITE;
                end else begin
                    prod_next    = mul_a * mul_b;
                    gap_div_next = 1'b1;
                    state_next   = ST_LD2;
                end
            end
            ST_LD2: begin
                dvd_next     = {1'b0, prod_reg} + DVD_W'(gap);
                divisor_next = work_reg.count - 1'b1;
                rem_next     = '0;
                step_next    = '0;
                state_next   = ST_DIV2;
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = hit_slot_reg;
                if (gap_div_reg)
                    mem_wdata.mean_gap = dvd_reg[GAP_W-1:0];
                if (in_len_reg < work_reg.min_length)
                    mem_wdata.min_length = in_len_reg;
                if (in_len_reg > work_reg.max_length)
                    mem_wdata.max_length = in_len_reg;
                mem_wdata.last_time = in_ts_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            win_len_reg   <= WINDOW_LENGTH_RST;
            init_gap_reg  <= INITIAL_GAP_RST;
            win_start_reg <= '0;
            valid_reg     <= '0;
            scan_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            win_start_reg <= win_start_next;
            valid_reg     <= valid_next;
            scan_reg      <= scan_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en && cfg_index == REG_WINDOW_LENGTH)
                win_len_reg <= cfg_wdata;
            if (cfg_wr_en && cfg_index == REG_INITIAL_GAP)
                init_gap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            in_key_reg <= s_tdata[63:0];
            in_len_reg <= s_tdata[79:64];
            in_ts_reg  <= s_tdata[111:80];
        end
        end_act_reg    <= end_act_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        hit_slot_reg   <= hit_slot_next;
        work_reg       <= work_next;
        gap_div_reg    <= gap_div_next;
        prod_reg       <= prod_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        step_reg       <= step_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    // flow table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[slot];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after an accepted beat");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> divisor_reg != '0)
        else $error("divider running with zero divisor");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_WRITE || state_reg == ST_SR_SCAN))
        else $error("table write outside insert or merge");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FL_OUT && out_free |=> !valid_reg[$past(slot)])
        else $error("reported slot still live");

endmodule
